/* hdl/sre_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_pkg
// Shared widths, saturation limits, register indexes and control types of the
// star record delta encoder.
// ----------------------------------------------------------------------------
package sre_pkg;

  localparam int FieldW   = 32;
  localparam int ValW     = FieldW + 1;
  localparam int InvW     = 40;
  localparam int SplitW   = 20;
  localparam int InvHiW   = InvW - SplitW;
  localparam int ProdW    = ValW + SplitW;
  localparam int SumW     = ProdW + 1;
  localparam int CodeW    = 16;
  localparam int CapW     = CodeW + 1;
  localparam int IdW      = 32;
  localparam int NumRegs  = 6;
  localparam int RegIdxW  = $clog2(NumRegs);

  localparam int AngleShift = 44;
  localparam int ValueShift = 32;

  localparam logic [CapW-1:0] AngleCap    = CapW'(32767);
  localparam logic [CapW-1:0] PosCap      = CapW'(32767);
  localparam logic [CapW-1:0] NegCap      = CapW'(32768);
  localparam logic [CapW-1:0] ParallaxCap = CapW'(65535);
  localparam logic [CapW-1:0] ZeroCap     = '0;

  localparam logic [InvW-1:0] InvReset = InvW'(65536);

  typedef enum logic [RegIdxW-1:0] {
    RegInvRa       = RegIdxW'(0),
    RegInvDec      = RegIdxW'(1),
    RegInvMag      = RegIdxW'(2),
    RegInvColor    = RegIdxW'(3),
    RegInvMotion   = RegIdxW'(4),
    RegInvParallax = RegIdxW'(5)
  } sre_reg_t;

  typedef struct packed {
    logic e2;
    logic e3;
    logic e4;
  } sre_lane_en_t;

endpackage

/* hdl/star_record_delta_encoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_record_delta_encoder_unit
// Quantizes star records into packed codes with angle deltas.
// ----------------------------------------------------------------------------
// The unit takes one star record per clock while the output is not stalled.
// There are four stages: an input stage that forms the angle deltas, a sign
// and magnitude stage, a stage of split 33 by 20 bit multipliers, and the
// shift and saturate stage that drives the output register. Every stage holds
// its own beat, so a stalled output only backs up the pipeline once all four
// stages are full. Reciprocal unit registers are written through the cfg port;
// the user must write them only while no record is in flight, as the unit
// itself does not enforce this.
module star_record_delta_encoder_unit
  import sre_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [RegIdxW-1:0]       cfg_index,
  input  logic [InvW-1:0]          cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     first_star,
  input  logic signed [FieldW-1:0] right_ascension,
  input  logic signed [FieldW-1:0] declination,
  input  logic signed [FieldW-1:0] magnitude,
  input  logic signed [FieldW-1:0] color_index,
  input  logic signed [FieldW-1:0] motion_ra,
  input  logic signed [FieldW-1:0] motion_dec,
  input  logic signed [FieldW-1:0] parallax_in,
  input  logic [IdW-1:0]           star_id,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CodeW-1:0]  delta_ra_code,
  output logic signed [CodeW-1:0]  delta_dec_code,
  output logic signed [CodeW-1:0]  magnitude_code,
  output logic signed [CodeW-1:0]  color_code,
  output logic signed [CodeW-1:0]  motion_ra_code,
  output logic signed [CodeW-1:0]  motion_dec_code,
  output logic [CodeW-1:0]         parallax_code,
  output logic [IdW-1:0]           star_id_out
);

  logic [InvW-1:0] inv_ra;
  logic [InvW-1:0] inv_dec;
  logic [InvW-1:0] inv_mag;
  logic [InvW-1:0] inv_color;
  logic [InvW-1:0] inv_motion;
  logic [InvW-1:0] inv_parallax;

  logic v1, v2, v3, v4;
  logic go1, go2, go3, go4;
  logic free1, free2, free3, free4;
  sre_lane_en_t en;

  logic signed [ValW-1:0]   d_ra;
  logic signed [ValW-1:0]   d_dec;
  logic signed [FieldW-1:0] mag1, col1, mra1, mdec1, par1;
  logic [IdW-1:0]           id1, id2, id3;

  logic [CodeW-1:0] ra_c, dec_c, mag_c, col_c, mra_c, mdec_c;

  // stage handshake, each stage loads when it is empty or drains
  assign free4 = !v4 || out_ready;
  assign go4   = v3 && free4;
  assign free3 = !v3 || go4;
  assign go3   = v2 && free3;
  assign free2 = !v2 || go3;
  assign go2   = v1 && free2;
  assign free1 = !v1 || go2;
  assign go1   = in_valid && free1;

  assign in_ready  = free1;
  assign out_valid = v4;
  assign en        = '{e2: go2, e3: go3, e4: go4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      inv_ra       <= InvReset;
      inv_dec      <= InvReset;
      inv_mag      <= InvReset;
      inv_color    <= InvReset;
      inv_motion   <= InvReset;
      inv_parallax <= InvReset;
    end else begin
      if (go1) begin
        v1 <= 1'b1;
      end else if (go2) begin
        v1 <= 1'b0;
      end
      if (go2) begin
        v2 <= 1'b1;
      end else if (go3) begin
        v2 <= 1'b0;
      end
      if (go3) begin
        v3 <= 1'b1;
      end else if (go4) begin
        v3 <= 1'b0;
      end
      if (go4) begin
        v4 <= 1'b1;
      end else if (out_ready) begin
        v4 <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          RegInvRa:       inv_ra       <= cfg_data;
          RegInvDec:      inv_dec      <= cfg_data;
          RegInvMag:      inv_mag      <= cfg_data;
          RegInvColor:    inv_color    <= cfg_data;
          RegInvMotion:   inv_motion   <= cfg_data;
          RegInvParallax: inv_parallax <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      mag1  <= magnitude;
      col1  <= color_index;
      mra1  <= motion_ra;
      mdec1 <= motion_dec;
      par1  <= parallax_in;
      id1   <= star_id;
    end
    if (go2) begin
      id2 <= id1;
    end
    if (go3) begin
      id3 <= id2;
    end
    if (go4) begin
      star_id_out <= id3;
    end
  end

  sre_front u_front (
    .clk             (clk),
    .rst             (rst),
    .load            (go1),
    .first_star      (first_star),
    .right_ascension (right_ascension),
    .declination     (declination),
    .d_ra            (d_ra),
    .d_dec           (d_dec)
  );

  sre_lane #(.SHIFT(AngleShift), .POS_CAP(AngleCap), .NEG_CAP(AngleCap)) u_ra (
    .clk (clk), .en (en), .val (d_ra), .inv (inv_ra), .code (ra_c)
  );

  sre_lane #(.SHIFT(AngleShift), .POS_CAP(AngleCap), .NEG_CAP(AngleCap)) u_dec (
    .clk (clk), .en (en), .val (d_dec), .inv (inv_dec), .code (dec_c)
  );

  sre_lane #(.SHIFT(ValueShift), .POS_CAP(PosCap), .NEG_CAP(NegCap)) u_mag (
    .clk (clk), .en (en), .val ({mag1[FieldW-1], mag1}), .inv (inv_mag),
    .code (mag_c)
  );

  sre_lane #(.SHIFT(ValueShift), .POS_CAP(PosCap), .NEG_CAP(NegCap)) u_col (
    .clk (clk), .en (en), .val ({col1[FieldW-1], col1}), .inv (inv_color),
    .code (col_c)
  );

  sre_lane #(.SHIFT(ValueShift), .POS_CAP(PosCap), .NEG_CAP(NegCap)) u_mra (
    .clk (clk), .en (en), .val ({mra1[FieldW-1], mra1}), .inv (inv_motion),
    .code (mra_c)
  );

  sre_lane #(.SHIFT(ValueShift), .POS_CAP(PosCap), .NEG_CAP(NegCap)) u_mdec (
    .clk (clk), .en (en), .val ({mdec1[FieldW-1], mdec1}), .inv (inv_motion),
    .code (mdec_c)
  );

  // negative parallax clamps to zero through a zero negative limit
  sre_lane #(.SHIFT(ValueShift), .POS_CAP(ParallaxCap), .NEG_CAP(ZeroCap)) u_par (
    .clk (clk), .en (en), .val ({par1[FieldW-1], par1}), .inv (inv_parallax),
    .code (parallax_code)
  );

  assign delta_ra_code   = signed'(ra_c);
  assign delta_dec_code  = signed'(dec_c);
  assign magnitude_code  = signed'(mag_c);
  assign color_code      = signed'(col_c);
  assign motion_ra_code  = signed'(mra_c);
  assign motion_dec_code = signed'(mdec_c);

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    v3 && v4 && !out_ready |=> v3 && v4)
    else $error("beat dropped while output stalled");

endmodule

/* hdl/sre_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_front
// Input stage for the angles: keeps the previous star's position and
// registers the right ascension and declination deltas of each beat.
// ----------------------------------------------------------------------------
module sre_front
  import sre_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic                    first_star,
  input  logic signed [FieldW-1:0] right_ascension,
  input  logic signed [FieldW-1:0] declination,
  output logic signed [ValW-1:0]   d_ra,
  output logic signed [ValW-1:0]   d_dec
);

  logic [FieldW-1:0]       last_ra;
  logic [FieldW-1:0]       last_dec;
  logic signed [ValW-1:0]  d_ra_next;
  logic signed [ValW-1:0]  d_dec_next;

  always_comb begin
    if (first_star) begin
      d_ra_next  = '0;
      d_dec_next = '0;
    end else begin
      d_ra_next  = {right_ascension[FieldW-1], right_ascension}
                 - {last_ra[FieldW-1], last_ra};
      d_dec_next = {declination[FieldW-1], declination}
                 - {last_dec[FieldW-1], last_dec};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ra  <= '0;
      last_dec <= '0;
    end else if (load) begin
      last_ra  <= right_ascension;
      last_dec <= declination;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_ra  <= d_ra_next;
      d_dec <= d_dec_next;
    end
  end

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    load && first_star |=> d_ra == '0 && d_dec == '0)
    else $error("first star delta not zero");

  a_track_pos: assert property (@(posedge clk) disable iff (rst)
    load |=> last_ra == $past(right_ascension) && last_dec == $past(declination))
    else $error("previous position not tracked");

endmodule

/* hdl/sre_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_lane
// One quantizer: sign and magnitude, split multiply by the reciprocal unit,
// then shift, saturate and restore the sign into a 16-bit code.
// ----------------------------------------------------------------------------
module sre_lane
  import sre_pkg::*;
#(
  parameter int              SHIFT   = ValueShift,
  parameter logic [CapW-1:0] POS_CAP = PosCap,
  parameter logic [CapW-1:0] NEG_CAP = NegCap
) (
  input  logic                   clk,
  input  sre_lane_en_t           en,
  input  logic signed [ValW-1:0] val,
  input  logic [InvW-1:0]        inv,
  output logic [CodeW-1:0]       code
);

  localparam int QShift = SHIFT - SplitW;

  logic                  neg2;
  logic [ValW-1:0]       mag2;
  logic                  neg3;
  logic [ProdW-1:0]      hi3;
  logic [ProdW-1:0]      lo3;
  logic [ValW-1:0]       mag_next;
  logic [SumW-1:0]       sum;
  logic [SumW-1:0]       q_full;
  logic [CapW-1:0]       cap;
  logic [CapW-1:0]       q_sat;
  logic [CodeW-1:0]      code_next;

  assign mag_next = val[ValW-1] ? (~val + ValW'(1)) : val;

  always_comb begin
    sum    = SumW'(hi3) + SumW'(lo3 >> SplitW);
    q_full = sum >> QShift;
    cap    = neg3 ? NEG_CAP : POS_CAP;
    q_sat  = (q_full > SumW'(cap)) ? cap : q_full[CapW-1:0];
    code_next = neg3 ? CodeW'(CapW'(0) - q_sat) : q_sat[CodeW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.e2) begin
      neg2 <= val[ValW-1];
      mag2 <= mag_next;
    end
    if (en.e3) begin
      neg3 <= neg2;
      hi3  <= ProdW'(mag2) * ProdW'(inv[InvW-1:SplitW]);
      lo3  <= ProdW'(mag2) * ProdW'(inv[SplitW-1:0]);
    end
    if (en.e4) begin
      code <= code_next;
    end
  end

  a_pos_cap: assert property (@(posedge clk)
    en.e4 && !neg3 |=> {1'b0, code} <= POS_CAP)
    else $error("positive code above limit");

  a_neg_sign: assert property (@(posedge clk)
    en.e4 && neg3 |=> code == '0 || code[CodeW-1])
    else $error("negative code lost its sign");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the star record delta encoder. A short table of
// star records is sent first, with the codes for unity unit registers typed
// in where they are plain to read. Phases of catalog runs with random content
// follow under different unit settings and flow-control patterns. Every returned
// record is checked field by field, against the typed-in codes where given and
// against an in-bench encoder otherwise.
module tb_top;
  import sre_pkg::*;

  localparam int HoldCycles = 300;
  localparam int DirRows = 10;
  localparam logic [RegIdxW-1:0] RegPastEnd = RegIdxW'(NumRegs);

  typedef enum {UnitsMax, UnitsZero, UnitsMixed} unit_set_t;

  typedef struct packed {
    logic             first;
    logic [FieldW-1:0] ra;
    logic [FieldW-1:0] dec;
    logic [FieldW-1:0] mag;
    logic [FieldW-1:0] color;
    logic [FieldW-1:0] mot_ra;
    logic [FieldW-1:0] mot_dec;
    logic [FieldW-1:0] parallax;
    logic [IdW-1:0]    id;
  } star_in_t;

  typedef struct packed {
    logic [CodeW-1:0] d_ra;
    logic [CodeW-1:0] d_dec;
    logic [CodeW-1:0] mag;
    logic [CodeW-1:0] color;
    logic [CodeW-1:0] mot_ra;
    logic [CodeW-1:0] mot_dec;
    logic [CodeW-1:0] parallax;
    logic [IdW-1:0]   id;
  } star_code_t;

  typedef struct packed {
    star_in_t   rec;
    logic       known;
    star_code_t want;
  } dir_row_t;

  // codes below hold for unity unit registers straight after reset
  localparam dir_row_t DIRECTED [DirRows] = '{
    '{'{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h0005_8000, 32'hFFFA_8000, 32'hFFFF_0000, 32'h0000_0000}, 1'b1,
      '{16'sd7, -16'sd8, 16'sd32767, -16'sd32768, 16'sd5, -16'sd5, 16'd0,
        32'h0000_0000}},
    '{'{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_FFFF,
        32'hFFFF_0001, 32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'd32767, 32'hFFFF_FFFF}},
    '{'{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h0001_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h1234_5678}, 1'b1,
      '{16'sd15, -16'sd15, -16'sd1, 16'sd1, 16'sd32767, -16'sd32768, 16'd0,
        32'h1234_5678}},
    '{'{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
        32'hFFFF_8000, 32'h0000_8000, 32'h0001_0000, 32'h0000_0001}, 1'b1,
      '{16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 16'sd0, 16'sd0, 16'd1,
        32'h0000_0001}},
    '{'{1'b0, 32'h1000_0000, 32'hF000_0000, 32'h0003_0000, 32'hFFFD_0000,
        32'h7FFF_0000, 32'h8001_0000, 32'h0000_FFFF, 32'hA5A5_A5A5}, 1'b1,
      '{-16'sd6, 16'sd7, 16'sd3, -16'sd3, 16'sd32767, -16'sd32767, 16'd0,
        32'hA5A5_A5A5}},
    '{'{1'b1, 32'h0123_4567, 32'hFEDC_BA98, 32'h0004_2000, 32'h0000_C000,
        32'hFFFF_F000, 32'h0000_0800, 32'h0002_8000, 32'h0000_0005}, 1'b0, '0},
    '{'{1'b0, 32'h0123_9999, 32'hFEDC_0000, 32'hFFF0_0001, 32'h0100_0000,
        32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_0006}, 1'b0, '0},
    '{'{1'b0, 32'h0F00_0000, 32'hF100_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0001_8000, 32'hFFFE_8000, 32'h7FFF_0000, 32'h0000_0007}, 1'b0, '0},
    '{'{1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_AAAA}, 1'b0, '0},
    '{'{1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_5555}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [RegIdxW-1:0] cfg_index = '0;
  logic [InvW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic first_star = 1'b0;
  logic signed [FieldW-1:0] right_ascension = '0;
  logic signed [FieldW-1:0] declination = '0;
  logic signed [FieldW-1:0] magnitude = '0;
  logic signed [FieldW-1:0] color_index = '0;
  logic signed [FieldW-1:0] motion_ra = '0;
  logic signed [FieldW-1:0] motion_dec = '0;
  logic signed [FieldW-1:0] parallax_in = '0;
  logic [IdW-1:0] star_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CodeW-1:0] delta_ra_code;
  logic signed [CodeW-1:0] delta_dec_code;
  logic signed [CodeW-1:0] magnitude_code;
  logic signed [CodeW-1:0] color_code;
  logic signed [CodeW-1:0] motion_ra_code;
  logic signed [CodeW-1:0] motion_dec_code;
  logic [CodeW-1:0] parallax_code;
  logic [IdW-1:0] star_id_out;

  logic [InvW-1:0] inv_unit [NumRegs];
  logic [FieldW-1:0] prev_ra;
  logic [FieldW-1:0] prev_dec;
  star_code_t codes_due [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;

  star_record_delta_encoder_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .first_star      (first_star),
    .right_ascension (right_ascension),
    .declination     (declination),
    .magnitude       (magnitude),
    .color_index     (color_index),
    .motion_ra       (motion_ra),
    .motion_dec      (motion_dec),
    .parallax_in     (parallax_in),
    .star_id         (star_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .delta_ra_code   (delta_ra_code),
    .delta_dec_code  (delta_dec_code),
    .magnitude_code  (magnitude_code),
    .color_code      (color_code),
    .motion_ra_code  (motion_ra_code),
    .motion_dec_code (motion_dec_code),
    .parallax_code   (parallax_code),
    .star_id_out     (star_id_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // exact product, truncation toward zero, then saturation
  function automatic logic [CodeW-1:0] quantize(logic signed [ValW-1:0] v,
                                                logic [InvW-1:0] inv, int shift,
                                                logic [CapW-1:0] pos_cap,
                                                logic [CapW-1:0] neg_cap);
    logic [ValW-1:0] mag;
    logic [ValW+InvW-1:0] prod;
    logic [ValW+InvW-1:0] q;
    mag = v[ValW-1] ? ValW'(-v) : ValW'(v);
    prod = (ValW+InvW)'(mag) * (ValW+InvW)'(inv);
    q = prod >> shift;
    if (v[ValW-1]) begin
      if (q > (ValW+InvW)'(neg_cap)) q = (ValW+InvW)'(neg_cap);
      return CodeW'(-q);
    end
    if (q > (ValW+InvW)'(pos_cap)) q = (ValW+InvW)'(pos_cap);
    return CodeW'(q);
  endfunction

  function automatic logic signed [ValW-1:0] widen(logic [FieldW-1:0] w);
    return $signed({w[FieldW-1], w});
  endfunction

  function automatic star_code_t encode_star(star_in_t s);
    star_code_t c;
    logic signed [ValW-1:0] d_ra;
    logic signed [ValW-1:0] d_dec;
    d_ra = s.first ? '0 : widen(s.ra) - widen(prev_ra);
    d_dec = s.first ? '0 : widen(s.dec) - widen(prev_dec);
    c.d_ra = quantize(d_ra, inv_unit[RegInvRa], AngleShift, AngleCap, AngleCap);
    c.d_dec = quantize(d_dec, inv_unit[RegInvDec], AngleShift, AngleCap, AngleCap);
    c.mag = quantize(widen(s.mag), inv_unit[RegInvMag], ValueShift, PosCap, NegCap);
    c.color = quantize(widen(s.color), inv_unit[RegInvColor], ValueShift, PosCap, NegCap);
    c.mot_ra = quantize(widen(s.mot_ra), inv_unit[RegInvMotion], ValueShift, PosCap, NegCap);
    c.mot_dec = quantize(widen(s.mot_dec), inv_unit[RegInvMotion], ValueShift, PosCap,
                         NegCap);
    c.parallax = quantize(widen(s.parallax), inv_unit[RegInvParallax], ValueShift,
                          ParallaxCap, ZeroCap);
    c.id = s.id;
    prev_ra = s.ra;
    prev_dec = s.dec;
    return c;
  endfunction

  function automatic logic [FieldW-1:0] rand_word();
    logic [FieldW-1:0] v;
    v = $urandom;
    case ($urandom_range(2))
      0: return v;
      1: begin
        v = v >> $urandom_range(31);
        return $urandom_range(1) ? -v : v;
      end
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [FieldW-1:0] small_step();
    logic [FieldW-1:0] v;
    v = $urandom >> $urandom_range(4, 31);
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic note_mismatch(string what, logic [IdW-1:0] got, logic [IdW-1:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_star(star_in_t s, logic known, star_code_t want);
    star_code_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_star <= s.first;
    right_ascension <= s.ra;
    declination <= s.dec;
    magnitude <= s.mag;
    color_index <= s.color;
    motion_ra <= s.mot_ra;
    motion_dec <= s.mot_dec;
    parallax_in <= s.parallax;
    star_id <= s.id;
    do @(posedge clk); while (!in_ready);
    c = encode_star(s);
    codes_due.insert(codes_due.size(), known ? want : c);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (codes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_units(unit_set_t units);
    logic [InvW-1:0] val;
    for (int i = 0; i < NumRegs; i++) begin
      case (units)
        UnitsMax:  val = '1;
        UnitsZero: val = '0;
        default:   val = InvW'({$urandom, $urandom} >> $urandom_range(24, 63));
      endcase
      cfg_we <= 1'b1;
      cfg_index <= RegIdxW'(i);
      cfg_data <= val;
      inv_unit[i] = val;
      @(posedge clk);
    end
    // index past the register list must be ignored
    cfg_index <= RegPastEnd;
    cfg_data <= InvW'({$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_catalogs(int count);
    int sent;
    int run_len;
    logic [FieldW-1:0] ra;
    logic [FieldW-1:0] dec;
    star_in_t s;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        s = '{1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
        send_star(s, 1'b0, '0);
        sent++;
      end else begin
        run_len = $urandom_range(1, 12);
        ra = $urandom;
        dec = $urandom;
        for (int k = 0; k < run_len; k++) begin
          if (k > 0) begin
            ra = ra + small_step();
            dec = dec + small_step();
          end
          s.first = (k == 0) && ($urandom_range(4) != 0);
          s.ra = ra;
          s.dec = dec;
          s.mag = rand_word();
          s.color = rand_word();
          s.mot_ra = rand_word();
          s.mot_dec = rand_word();
          s.parallax = rand_word();
          s.id = $urandom;
          send_star(s, 1'b0, '0);
        end
        sent += run_len;
      end
    end
  endtask

  task automatic run_phase(unit_set_t units, int send_pct, int recv_pct, int count,
                           logic squeeze);
    settle();
    program_units(units);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) begin
      hold_start <= 1'b1;
      @(posedge clk);
      hold_start <= 1'b0;
    end
    send_catalogs(count);
  endtask

  // receiver side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_ready <= !hold_start && hold_left == 0 && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : record_check
    star_code_t want;
    if (!rst && out_valid && out_ready) begin
      if (codes_due.size() == 0) begin
        note_mismatch("record with nothing due, id", star_id_out, '0);
      end else begin
        want = codes_due.pop_front();
        if (delta_ra_code !== want.d_ra)
          note_mismatch("delta_ra_code", IdW'(delta_ra_code), IdW'(want.d_ra));
        if (delta_dec_code !== want.d_dec)
          note_mismatch("delta_dec_code", IdW'(delta_dec_code), IdW'(want.d_dec));
        if (magnitude_code !== want.mag)
          note_mismatch("magnitude_code", IdW'(magnitude_code), IdW'(want.mag));
        if (color_code !== want.color)
          note_mismatch("color_code", IdW'(color_code), IdW'(want.color));
        if (motion_ra_code !== want.mot_ra)
          note_mismatch("motion_ra_code", IdW'(motion_ra_code), IdW'(want.mot_ra));
        if (motion_dec_code !== want.mot_dec)
          note_mismatch("motion_dec_code", IdW'(motion_dec_code), IdW'(want.mot_dec));
        if (parallax_code !== want.parallax)
          note_mismatch("parallax_code", IdW'(parallax_code), IdW'(want.parallax));
        if (star_id_out !== want.id)
          note_mismatch("star_id_out", star_id_out, want.id);
      end
    end
  end

  initial begin
    for (int i = 0; i < NumRegs; i++) inv_unit[i] = InvReset;
    prev_ra = '0;
    prev_dec = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no first star after reset: deltas run from a zero position
    for (int r = 0; r < DirRows; r++)
      send_star(DIRECTED[r].rec, DIRECTED[r].known, DIRECTED[r].want);

    run_phase(UnitsMixed, 0, 0, 120, 1'b0);
    run_phase(UnitsMax, 76, 0, 100, 1'b0);
    run_phase(UnitsZero, 0, 76, 50, 1'b0);
    run_phase(UnitsMixed, 35, 35, 130, 1'b0);
    run_phase(UnitsMixed, 0, 0, 100, 1'b1);
    run_phase(UnitsMixed, 0, 76, 100, 1'b0);
    run_phase(UnitsMax, 35, 35, 40, 1'b0);
    run_phase(UnitsMixed, 76, 0, 80, 1'b0);
    settle();
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
